@@ hw/rtl/bounded_byte_stream_fifo_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded byte stream FIFO
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_BYTE_STREAM_FIFO_DEFINES_SVH
`define BOUNDED_BYTE_STREAM_FIFO_DEFINES_SVH

`ifndef SYNTHESIS

`define BBSF_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("bbsf: check failed");

`define BBSF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbsf: check failed");

`define BBSF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbsf: check failed");

`else

`define BBSF_ASSERT_ALWAYS(name, expr)
`define BBSF_ASSERT_IMPL(name, ante, cons)
`define BBSF_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ hw/rtl/bbsf_pkg.sv @@
// ----------------------------------------------------------------------------
// bbsf_pkg
// Types and fixed constants shared by the bounded byte stream FIFO.
// ----------------------------------------------------------------------------
package bbsf_pkg;

  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 2;
  localparam int LEN_W   = 13;
  localparam int FILL_W  = 13;
  localparam int CAP_W   = 13;
  localparam int TOTAL_W = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd3;

  typedef logic [CAP_W-1:0] cap_word_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               last;
    logic               write_accepted;
    logic [FILL_W-1:0]  fill_level;
    logic               input_closed;
    logic               end_of_stream;
    logic [TOTAL_W-1:0] total_written;
    logic [TOTAL_W-1:0] total_read;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESULT,
    S_PEEK_READ,
    S_PEEK_EMIT
  } state_t;

  typedef struct packed {
    logic exec;
    logic load_result;
    logic rd_en;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_peek;
    logic peek_empty;
    logic peek_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/bbsf_chan_if.sv @@
// ----------------------------------------------------------------------------
// bbsf_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface bbsf_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ hw/rtl/bbsf_dp.sv @@
// ----------------------------------------------------------------------------
// bbsf_dp
// Datapath: byte store, pointers, counters, flags, totals and result register.
// ----------------------------------------------------------------------------
`include "bounded_byte_stream_fifo_defines.svh"

module bbsf_dp #(
  parameter int DEPTH    = 4096,
  parameter int PEEK_MAX = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bbsf_pkg::ctl_cmd_t   cmd,
  output bbsf_pkg::dp_stat_t   stat,
  input  bbsf_pkg::in_item_t   in_item,
  input  logic                 cfg_valid,
  input  bbsf_pkg::cap_word_t  cfg_data,
  output logic                 cfg_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output bbsf_pkg::out_item_t  out_item
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = bbsf_pkg::FILL_W;
  localparam int PK_W   = $clog2(PEEK_MAX + 1);
  localparam int SUM_W  = ((PTR_W > FILL_W) ? PTR_W : FILL_W) + 1;
  localparam logic [31:0]      DEPTH_X   = 32'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
  localparam logic [FILL_W-1:0] PEEK_LIM = FILL_W'(PEEK_MAX);

  logic [bbsf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [bbsf_pkg::BYTE_W-1:0] rd_data_r;

  bbsf_pkg::cap_word_t         cap_r;
  logic [PTR_W-1:0]            head_r, head_nxt;
  logic [PTR_W-1:0]            tail_r, tail_nxt;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  logic                        ended_r, ended_nxt;
  logic                        eos_r, eos_nxt;
  logic                        wa_r, wa_nxt;
  logic [bbsf_pkg::TOTAL_W-1:0] written_r, written_nxt;
  logic [bbsf_pkg::TOTAL_W-1:0] read_r, read_nxt;
  logic [PTR_W-1:0]            pk_ptr_r, pk_ptr_nxt;
  logic [PK_W-1:0]             pk_left_r, pk_left_nxt;
  logic                        out_valid_r, out_valid_nxt;
  bbsf_pkg::out_item_t         out_item_r, out_item_nxt;

  logic [31:0]       cap_eff;
  logic              wr_ok;
  logic              wr_en;
  logic [FILL_W-1:0] pop_n;
  logic [FILL_W-1:0] peek_n;
  logic [FILL_W-1:0] fill_after_pop;
  logic [SUM_W-1:0]  head_sum;
  logic [SUM_W-1:0]  head_wrap;
  logic              pk_last;

  assign cap_eff = (32'(cap_r) > DEPTH_X) ? DEPTH_X : 32'(cap_r);
  assign wr_ok   = 32'(fill_r) < cap_eff;
  assign wr_en   = cmd.exec && (in_item.command == bbsf_pkg::CMD_WRITE) && wr_ok;

  assign pop_n          = (in_item.length < fill_r) ? in_item.length : fill_r;
  assign peek_n         = (pop_n < PEEK_LIM) ? pop_n : PEEK_LIM;
  assign fill_after_pop = fill_r - pop_n;
  assign head_sum       = SUM_W'(head_r) + SUM_W'(pop_n);
  assign head_wrap      = (head_sum >= DEPTH_S) ? (head_sum - DEPTH_S) : head_sum;
  assign pk_last        = (pk_left_r == PK_W'(1));

  assign stat.is_peek    = (in_item.command == bbsf_pkg::CMD_PEEK);
  assign stat.peek_empty = (peek_n == '0);
  assign stat.peek_last  = pk_last;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    ended_nxt   = ended_r;
    eos_nxt     = eos_r;
    wa_nxt      = wa_r;
    written_nxt = written_r;
    read_nxt    = read_r;
    pk_ptr_nxt  = pk_ptr_r;
    pk_left_nxt = pk_left_r;
    if (cmd.exec) begin
      wa_nxt = 1'b0;
      case (in_item.command)
        bbsf_pkg::CMD_WRITE: begin
          if (wr_ok) begin
            tail_nxt    = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
            fill_nxt    = fill_r + FILL_W'(1);
            written_nxt = written_r + 64'd1;
            wa_nxt      = 1'b1;
            eos_nxt     = 1'b0;
          end else begin
            eos_nxt = ended_r && (fill_r == '0);
          end
        end
        bbsf_pkg::CMD_END: begin
          ended_nxt = 1'b1;
          eos_nxt   = (fill_r == '0);
        end
        bbsf_pkg::CMD_PEEK: begin
          pk_ptr_nxt  = head_r;
          pk_left_nxt = PK_W'(peek_n);
        end
        bbsf_pkg::CMD_POP: begin
          head_nxt = head_wrap[PTR_W-1:0];
          fill_nxt = fill_after_pop;
          read_nxt = read_r + 64'(pop_n);
          eos_nxt  = ended_r && (fill_after_pop == '0);
        end
        default: begin
          wa_nxt = 1'b0;
        end
      endcase
    end
    if (cmd.emit) begin
      pk_ptr_nxt  = (pk_ptr_r == PTR_LAST) ? '0 : pk_ptr_r + PTR_W'(1);
      pk_left_nxt = pk_left_r - PK_W'(1);
    end
  end

  always_comb begin
    out_item_nxt                = out_item_r;
    out_valid_nxt               = out_valid_r && !out_ready;
    if (cmd.load_result || cmd.emit) begin
      out_valid_nxt                = 1'b1;
      out_item_nxt.out_byte        = cmd.emit ? rd_data_r : '0;
      out_item_nxt.byte_valid      = cmd.emit;
      out_item_nxt.last            = cmd.emit ? pk_last : 1'b1;
      out_item_nxt.write_accepted  = cmd.load_result && wa_r;
      out_item_nxt.fill_level      = fill_r;
      out_item_nxt.input_closed    = ended_r;
      out_item_nxt.end_of_stream   = eos_r;
      out_item_nxt.total_written   = written_r;
      out_item_nxt.total_read      = read_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= in_item.data_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[pk_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= bbsf_pkg::CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      ended_r     <= 1'b0;
      eos_r       <= 1'b0;
      wa_r        <= 1'b0;
      written_r   <= '0;
      read_r      <= '0;
      pk_ptr_r    <= '0;
      pk_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      ended_r     <= ended_nxt;
      eos_r       <= eos_nxt;
      wa_r        <= wa_nxt;
      written_r   <= written_nxt;
      read_r      <= read_nxt;
      pk_ptr_r    <= pk_ptr_nxt;
      pk_left_r   <= pk_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  `BBSF_ASSERT_ALWAYS(a_eos_means_drained, !eos_r || (ended_r && (fill_r == '0)))
  `BBSF_ASSERT_NEXT(a_full_write_dropped, cmd.exec && (in_item.command == bbsf_pkg::CMD_WRITE) && !wr_ok, $stable(written_r))
  `BBSF_ASSERT_IMPL(a_no_result_overrun, cmd.load_result || cmd.emit, !out_valid_r || out_ready)

endmodule

@@ hw/rtl/bbsf_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbsf_ctrl
// Controller: takes one command word at a time and sequences the datapath.
// ----------------------------------------------------------------------------
`include "bounded_byte_stream_fifo_defines.svh"

module bbsf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbsf_pkg::dp_stat_t stat,
  output bbsf_pkg::ctl_cmd_t cmd
);

  bbsf_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bbsf_pkg::S_IDLE: begin
        if (in_valid) begin
          if (stat.is_peek && !stat.peek_empty) begin
            state_nxt = bbsf_pkg::S_PEEK_READ;
          end else begin
            state_nxt = bbsf_pkg::S_RESULT;
          end
        end
      end
      bbsf_pkg::S_RESULT: begin
        if (stat.out_free) begin
          state_nxt = bbsf_pkg::S_IDLE;
        end
      end
      bbsf_pkg::S_PEEK_READ: begin
        state_nxt = bbsf_pkg::S_PEEK_EMIT;
      end
      bbsf_pkg::S_PEEK_EMIT: begin
        if (stat.out_free) begin
          state_nxt = stat.peek_last ? bbsf_pkg::S_IDLE : bbsf_pkg::S_PEEK_READ;
        end
      end
      default: begin
        state_nxt = bbsf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.exec        = 1'b0;
    cmd.load_result = 1'b0;
    cmd.rd_en       = 1'b0;
    cmd.emit        = 1'b0;
    case (state_r)
      bbsf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      bbsf_pkg::S_RESULT: begin
        cmd.load_result = stat.out_free;
      end
      bbsf_pkg::S_PEEK_READ: begin
        cmd.rd_en = 1'b1;
      end
      bbsf_pkg::S_PEEK_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbsf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BBSF_ASSERT_ALWAYS(a_one_action, $onehot0({cmd.exec, cmd.load_result, cmd.rd_en, cmd.emit}))
  `BBSF_ASSERT_NEXT(a_read_then_emit, cmd.rd_en, state_r == bbsf_pkg::S_PEEK_EMIT)
  `BBSF_ASSERT_NEXT(a_peek_starts_read, cmd.exec && stat.is_peek && !stat.peek_empty, cmd.rd_en)

endmodule

@@ hw/rtl/bounded_byte_stream_fifo.sv @@
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo
// Bounded byte FIFO with end-of-input marking, peek and pop commands.
//
//   channel  dir  payload                       handshake
//   in_ch    in   command, data_byte, length    valid/ready
//   out_ch   out  result word (nine fields)     valid/ready
//   cfg_ch   in   capacity (13 bits)            valid/ready, always ready
//
// Write, end input, pop and an empty peek are accepted, then answered with a result.
// A peek of n bytes reads and emits each byte in turn, as the store read port is registered.
// Reset is synchronous; the store needs no clearing pass.
// A stalled result holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo #(
  parameter int DEPTH    = 4096,
  parameter int PEEK_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  bbsf_chan_if.sink   in_ch,
  bbsf_chan_if.source out_ch,
  bbsf_chan_if.sink   cfg_ch
);

  bbsf_pkg::ctl_cmd_t  cmd;
  bbsf_pkg::dp_stat_t  stat;
  bbsf_pkg::in_item_t  in_item;
  bbsf_pkg::out_item_t out_item;
  bbsf_pkg::cap_word_t cfg_data;
  logic                in_ready;
  logic                out_valid;
  logic                cfg_ready;

  assign in_item      = in_ch.data;
  assign cfg_data     = cfg_ch.data;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = cfg_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  bbsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbsf_dp #(
    .DEPTH    (DEPTH),
    .PEEK_MAX (PEEK_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
